[rtl/core/cpeq_pkg.sv]
// Shared types and constants for the coalescing priority event queue.
`timescale 1ns / 1ps
`default_nettype none

package cpeq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OP_W        = 2;
    localparam int CODE_W      = 3;
    localparam int PRI_W       = 16;
    localparam int TIME_W      = 32;

    // operation codes of an input item
    typedef enum logic [OP_W-1:0] {
        OP_RAISE   = 2'd0,
        OP_POLL    = 2'd1,
        OP_PREEMPT = 2'd2
    } op_t;

    // one queue entry
    typedef struct packed {
        logic [CODE_W-1:0]        code;
        logic signed [PRI_W-1:0]  pri;
        logic [TIME_W-1:0]        stamp;
    } entry_t;

    // command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_RAISE,
        CMD_REMOVE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                cmd;
        entry_t                   ent;        // entry carried by a raise
        logic                     hit_any;    // raise code already pending
        logic                     full;       // every cell occupied
        logic [IDX_W-1:0]         rm_idx;     // cell removed by a poll
        logic signed [PRI_W-1:0]  cur;        // running priority for preempt
    } cell_ctrl_t;

    // running maximum handed down the chain during a poll scan
    typedef struct packed {
        logic              has;
        entry_t            ent;
        logic [IDX_W-1:0]  idx;
    } token_t;

endpackage

`default_nettype wire

[rtl/core/cpeq_if.sv]
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
`default_nettype none

interface cpeq_req_if import cpeq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [CODE_W-1:0]        event_code;
    logic signed [PRI_W-1:0]  event_priority;
    logic [TIME_W-1:0]        now_time;
    logic signed [PRI_W-1:0]  run_priority;

    modport source (
        output valid, op, event_code, event_priority, now_time, run_priority,
        input  ready
    );
    modport sink (
        input  valid, op, event_code, event_priority, now_time, run_priority,
        output ready
    );
endinterface

interface cpeq_rsp_if import cpeq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [CODE_W-1:0]        out_event;
    logic signed [PRI_W-1:0]  out_priority;
    logic [TIME_W-1:0]        out_time;
    logic                     preempt;

    modport source (
        output valid, found, out_event, out_priority, out_time, preempt,
        input  ready
    );
    modport sink (
        input  valid, found, out_event, out_priority, out_time, preempt,
        output ready
    );
endinterface

`default_nettype wire

[rtl/core/cpeq_cell.sv]
// One queue cell: holds an entry, shifts with its neighbour, passes the scan token on.
`timescale 1ns / 1ps
`default_nettype none

module cpeq_cell import cpeq_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  my_idx,
    input  cell_ctrl_t        ctrl,
    input  logic              prev_valid,
    input  logic              nb_valid,
    input  entry_t            nb_ent,
    input  token_t            tok_in,
    output logic              cell_valid,
    output entry_t            cell_ent,
    output token_t            tok_out,
    output logic              hit,
    output logic              above
);

    logic    valid_reg, valid_next;
    entry_t  ent_reg, ent_next;
    token_t  tok_reg, tok_next;

    // compares against the broadcast operands
    assign hit   = valid_reg && (ent_reg.code == ctrl.ent.code);
    assign above = valid_reg && ($signed(ent_reg.pri) > $signed(ctrl.cur));

    // entry update
    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        case (ctrl.cmd)
            CMD_RAISE:
            begin
                if (ctrl.hit_any)
                begin
                    if (hit)
                    begin
                        if ($signed(ctrl.ent.pri) > $signed(ent_reg.pri))
                            ent_next.pri = ctrl.ent.pri;
                        ent_next.stamp = ctrl.ent.stamp;
                    end
                end
                else if (ctrl.full)
                begin
                    // drop the head: everyone moves one place towards it
                    ent_next   = nb_ent;
                    valid_next = 1'b1;
                end
                else if (!valid_reg && prev_valid)
                begin
                    ent_next   = ctrl.ent;
                    valid_next = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (my_idx >= ctrl.rm_idx)
                begin
                    ent_next   = nb_ent;
                    valid_next = nb_valid;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // running maximum: strictly greater replaces, so ties keep the earlier cell
    always_comb
    begin
        tok_next = tok_in;
        if (valid_reg && (!tok_in.has || ($signed(ent_reg.pri) > $signed(tok_in.ent.pri))))
        begin
            tok_next.has = 1'b1;
            tok_next.ent = ent_reg;
            tok_next.idx = my_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign cell_valid = valid_reg;
    assign cell_ent   = ent_reg;
    assign tok_out    = tok_reg;

endmodule

`default_nettype wire

[rtl/core/coalescing_priority_event_queue_top.sv]
// Top level of the coalescing priority event queue: control and the row of cells.
//
// Usage:
//   req carries one operation per item (raise, poll or preempt query); rsp returns
//   exactly one result item per request item, in order. Both are valid/ready
//   channels; an item moves on a rising edge with valid and ready high.
//   Pending events live in a row of QUEUE_DEPTH cells, head at cell 0. Each code
//   is held at most once; a repeated raise merges into its entry.
//   Sequence: a raise, preempt query or unused op goes from idle straight to the
//   done state, where its result is registered and the block returns to idle. A
//   poll first scans the row with a token that moves one cell per cycle, in a scan
//   state that steps a counter over every cell, and then goes to the done state;
//   the chain length sets the length of the scan before the result is registered.
//   One item is in work at a time. The result register parts the channels: a
//   new item is accepted while a result waits, but it cannot finish until rsp
//   has taken the previous result, so a stalled receiver holds the block.
//   Reset (rst_n low, asynchronous) empties the queue and drops any result.
`timescale 1ns / 1ps
`default_nettype none

module coalescing_priority_event_queue_top import cpeq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cpeq_req_if.sink    req,
    cpeq_rsp_if.source  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic [OP_W-1:0]          op_reg, op_next;
    entry_t                   arg_reg, arg_next;
    logic signed [PRI_W-1:0]  cur_reg, cur_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    entry_t                   res_reg, res_next;
    logic                     preempt_reg, preempt_next;

    cell_ctrl_t               ctrl;
    logic                     commit;
    logic                     req_fire;

    logic [QUEUE_DEPTH-1:0]   vld_vec;
    logic [QUEUE_DEPTH-1:0]   hit_vec;
    logic [QUEUE_DEPTH-1:0]   above_vec;
    entry_t                   ent_arr [QUEUE_DEPTH];
    token_t                   tok_arr [QUEUE_DEPTH];
    token_t                   tok_last;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign commit    = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);
    assign tok_last  = tok_arr[QUEUE_DEPTH-1];

    // command to the cells
    always_comb
    begin
        ctrl.cmd     = CMD_HOLD;
        ctrl.ent     = arg_reg;
        ctrl.hit_any = |hit_vec;
        ctrl.full    = vld_vec[QUEUE_DEPTH-1];
        ctrl.rm_idx  = tok_last.idx;
        ctrl.cur     = cur_reg;
        if (commit)
        begin
            case (op_reg)
                OP_RAISE:
                begin
                    if (arg_reg.code != '0)
                        ctrl.cmd = CMD_RAISE;
                end
                OP_POLL:
                begin
                    if (tok_last.has)
                        ctrl.cmd = CMD_REMOVE;
                end
                default:
                begin
                    ctrl.cmd = CMD_HOLD;
                end
            endcase
        end
    end

    // sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        arg_next       = arg_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        res_next       = res_reg;
        preempt_next   = preempt_reg;

        if (rsp.valid && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next        = req.op;
                    arg_next.code  = req.event_code;
                    arg_next.pri   = req.event_priority;
                    arg_next.stamp = req.now_time;
                    cur_next       = req.run_priority;
                    cnt_next       = '0;
                    state_next     = (req.op == OP_POLL) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(QUEUE_DEPTH - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    res_next       = '0;
                    preempt_next   = 1'b0;
                    case (op_reg)
                        OP_POLL:
                        begin
                            if (tok_last.has)
                            begin
                                found_next = 1'b1;
                                res_next   = tok_last.ent;
                            end
                        end
                        OP_PREEMPT:
                        begin
                            preempt_next = |above_vec;
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= '0;
            arg_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            res_reg       <= '0;
            preempt_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            arg_reg       <= arg_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            res_reg       <= res_next;
            preempt_reg   <= preempt_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = found_reg;
    assign rsp.out_event    = res_reg.code;
    assign rsp.out_priority = res_reg.pri;
    assign rsp.out_time     = res_reg.stamp;
    assign rsp.preempt      = preempt_reg;

    // row of cells, head at index 0
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic    prev_valid;
        logic    nb_valid;
        entry_t  nb_ent;
        token_t  tok_in;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
            assign tok_in     = '0;
        end
        else
        begin : g_body
            assign prev_valid = vld_vec[i-1];
            assign tok_in     = tok_arr[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            // a full raise shifts the new entry in at the tail
            assign nb_valid = 1'b0;
            assign nb_ent   = arg_reg;
        end
        else
        begin : g_mid
            assign nb_valid = vld_vec[i+1];
            assign nb_ent   = ent_arr[i+1];
        end

        cpeq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .my_idx     (IDX_W'(i)),
            .ctrl       (ctrl),
            .prev_valid (prev_valid),
            .nb_valid   (nb_valid),
            .nb_ent     (nb_ent),
            .tok_in     (tok_in),
            .cell_valid (vld_vec[i]),
            .cell_ent   (ent_arr[i]),
            .tok_out    (tok_arr[i]),
            .hit        (hit_vec[i]),
            .above      (above_vec[i])
        );
    end

    // occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec >> 1) & ~vld_vec) == '0)
        else $error("queue cells not contiguous");

    // coalescing keeps every pending code unique
    a_unique_code: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("event code pending in more than one cell");

    // a successful poll frees exactly one cell
    a_poll_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.cmd == CMD_REMOVE) |=>
            ($countones(vld_vec) == $countones($past(vld_vec)) - 1))
        else $error("poll did not remove exactly one entry");

endmodule

`default_nettype wire
